[hdl/kth_ancestor_binary_lifting_macros.svh]
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting assertion macros
// Shared property shorthands for the k-th ancestor engine.
// ----------------------------------------------------------------------------
`ifndef KTH_ANCESTOR_BINARY_LIFTING_MACROS_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_MACROS_SVH

// same-cycle implication
`define KABL_ASSERT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KABL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/kabl_pkg.sv]
// ----------------------------------------------------------------------------
// kabl_pkg
// Field widths, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package kabl_pkg;

    localparam int CFG_W    = 11;
    localparam int REQ_W    = 2;
    localparam int NODE_W   = 10;
    localparam int PARENT_W = 11;
    localparam int STEPS_W  = 10;

    localparam int DEF_MAX_NODES  = 1024;
    localparam int DEF_LOG_LEVELS = 10;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BUILD = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    typedef struct packed {
        logic take;       // latch item fields
        logic load_wr;    // write parent into level 0
        logic b_rd_self;  // build: read own entry at source level
        logic b_rd_f1;    // build: read entry of first hop
        logic b_wr;       // build: write target level entry
        logic b_next;     // build: advance node / level
        logic q_rd;       // query: read entry of current node
        logic q_shift;    // query: drop low bit of k, next level
        logic q_follow;   // query: move to read entry
        logic q_fail;     // query: mark not found
        logic out_load;   // load result register
    } t_dp_cmd;

    typedef struct packed {
        logic rd_live;
        logic b_last_node;
        logic b_last_level;
        logic b_empty;
        logic q_end;
        logic k_lsb;
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/kabl_dp.sv]
// ----------------------------------------------------------------------------
// kabl_dp
// Jump table memory, build/query counters, node count and result register.
// ----------------------------------------------------------------------------
`include "kth_ancestor_binary_lifting_macros.svh"

module kabl_dp #(
    parameter int MAX_NODES  = kabl_pkg::DEF_MAX_NODES,
    parameter int LOG_LEVELS = kabl_pkg::DEF_LOG_LEVELS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kabl_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [kabl_pkg::NODE_W-1:0]         i_node_index,
    input  logic signed [kabl_pkg::PARENT_W-1:0] i_parent_index,
    input  logic [kabl_pkg::STEPS_W-1:0]        i_steps_up,
    input  kabl_pkg::t_dp_cmd                   i_cmd,
    output kabl_pkg::t_dp_sts                   o_sts,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic [kabl_pkg::NODE_W-1:0]         o_ancestor_index,
    output logic                                o_found
);
    import kabl_pkg::*;

    localparam int NW    = $clog2(MAX_NODES);
    localparam int LW    = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int AW    = LW + NW;
    localparam int EW    = NW + 1;
    localparam int DEPTH = LOG_LEVELS << NW;
    localparam int CW0   = $clog2(MAX_NODES + 1);
    localparam int XW    = (CW0 > CFG_W) ? CW0 : CFG_W;
    localparam logic [XW-1:0] MAXN           = XW'(MAX_NODES);
    localparam logic [LW-1:0] LVL_LAST_BUILD = LW'(LOG_LEVELS - 2);
    localparam logic [EW-1:0] ENTRY_NULL     = {1'b1, {NW{1'b0}}};

    logic [EW-1:0]      r_mem [DEPTH];
    logic [EW-1:0]      r_rd_data;
    logic [XW-1:0]      r_cnt;
    logic [LW-1:0]      r_lvl;
    logic [NW-1:0]      r_bi;
    logic [NW-1:0]      r_cur;
    logic [STEPS_W-1:0] r_k;
    logic               r_ok;
    logic               r_out_valid;
    logic [NODE_W-1:0]  r_anc;
    logic               r_found;

    logic [XW-1:0] n_cnt;
    logic [XW-1:0] node_ext, parent_ext, cfg_ext, cur_ext, bi_ext, rd_ext;
    logic [NW-1:0] rd_ptr;
    logic          rd_live;
    logic          parent_bad;
    logic [EW-1:0] load_entry, build_entry;
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [EW-1:0] wr_data;
    logic          out_pop;

    assign node_ext    = XW'(i_node_index);
    assign parent_ext  = XW'($unsigned(i_parent_index));
    assign cfg_ext     = XW'(i_cfg_data);
    assign cur_ext     = XW'(r_cur);
    assign bi_ext      = XW'(r_bi);
    assign parent_bad  = i_parent_index[PARENT_W-1] || (parent_ext >= MAXN);
    assign load_entry  = parent_bad ? ENTRY_NULL : {1'b0, parent_ext[NW-1:0]};
    assign rd_ptr      = r_rd_data[NW-1:0];
    assign rd_ext      = XW'(rd_ptr);
    assign rd_live     = !r_rd_data[EW-1] && (rd_ext < r_cnt);
    assign build_entry = rd_live ? {1'b0, rd_ptr} : ENTRY_NULL;
    assign n_cnt       = (cfg_ext > MAXN) ? MAXN : cfg_ext;
    assign out_pop     = r_out_valid && !i_stall;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = {LW'(0), node_ext[NW-1:0]};
        wr_data = load_entry;
        if (i_cmd.load_wr) begin
            wr_en = node_ext < MAXN;
        end else if (i_cmd.b_wr) begin
            wr_en   = 1'b1;
            wr_addr = {r_lvl + LW'(1), r_bi};
            wr_data = build_entry;
        end
    end

    always_comb begin
        rd_en   = i_cmd.b_rd_self || i_cmd.b_rd_f1 || i_cmd.q_rd;
        rd_addr = {r_lvl, r_cur};
        if (i_cmd.b_rd_self) begin
            rd_addr = {r_lvl, r_bi};
        end else if (i_cmd.b_rd_f1) begin
            rd_addr = {r_lvl, rd_ptr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= XW'(1);
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cnt <= n_cnt;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_pop) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.take) begin
                r_ok <= (node_ext < r_cnt) && ((i_steps_up >> LOG_LEVELS) == '0);
            end else if (i_cmd.q_fail) begin
                r_ok <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_lvl <= '0;
            r_bi  <= '0;
            r_cur <= node_ext[NW-1:0];
            r_k   <= i_steps_up;
        end else begin
            if (i_cmd.b_next) begin
                if (o_sts.b_last_node) begin
                    r_bi  <= '0;
                    r_lvl <= r_lvl + LW'(1);
                end else begin
                    r_bi <= r_bi + NW'(1);
                end
            end
            if (i_cmd.q_shift) begin
                r_k   <= r_k >> 1;
                r_lvl <= r_lvl + LW'(1);
            end
            if (i_cmd.q_follow) begin
                r_cur <= rd_ptr;
            end
        end
        if (i_cmd.out_load) begin
            r_anc   <= r_ok ? cur_ext[NODE_W-1:0] : '0;
            r_found <= r_ok;
        end
    end

    always_comb begin
        o_sts.rd_live      = rd_live;
        o_sts.b_last_node  = (bi_ext + XW'(1)) == r_cnt;
        o_sts.b_last_level = r_lvl == LVL_LAST_BUILD;
        o_sts.b_empty      = (r_cnt == '0) || (LOG_LEVELS == 1);
        o_sts.q_end        = !r_ok || (r_k == '0);
        o_sts.k_lsb        = r_k[0];
        o_sts.out_free     = !r_out_valid || !i_stall;
    end

    assign o_valid          = r_out_valid;
    assign o_ancestor_index = r_anc;
    assign o_found          = r_found;

    `KABL_ASSERT(a_one_read, i_clk, i_rst_n, 1'b1,
        $onehot0({i_cmd.b_rd_self, i_cmd.b_rd_f1, i_cmd.q_rd}), "multiple table reads")
    `KABL_ASSERT(a_one_write, i_clk, i_rst_n, 1'b1,
        $onehot0({i_cmd.load_wr, i_cmd.b_wr, rd_en}), "table read and write collide")
    `KABL_ASSERT(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_found,
        r_anc == '0, "not-found result carries nonzero index")

endmodule

[hdl/kabl_ctrl.sv]
// ----------------------------------------------------------------------------
// kabl_ctrl
// Sequencer for load, build and query items; drives datapath commands.
// ----------------------------------------------------------------------------
`include "kth_ancestor_binary_lifting_macros.svh"

module kabl_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [kabl_pkg::REQ_W-1:0] i_req_type,
    input  kabl_pkg::t_dp_sts          i_sts,
    output kabl_pkg::t_dp_cmd          o_cmd
);
    import kabl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_STEP,
        S_Q_WAIT,
        S_Q_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   take;

    assign o_stall = !i_rst_n || r_busy;
    assign take    = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    o_cmd.take = 1'b1;
                    unique case (i_req_type)
                        REQ_LOAD:  o_cmd.load_wr = 1'b1;
                        REQ_BUILD: begin
                            if (!i_sts.b_empty) begin
                                n_state = S_B_RD1;
                            end
                        end
                        REQ_QUERY: n_state = S_Q_STEP;
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_B_RD1: begin
                o_cmd.b_rd_self = 1'b1;
                n_state         = S_B_RD2;
            end
            S_B_RD2: begin
                if (i_sts.rd_live) begin
                    o_cmd.b_rd_f1 = 1'b1;
                    n_state       = S_B_WR;
                end else begin
                    o_cmd.b_wr   = 1'b1;
                    o_cmd.b_next = 1'b1;
                    n_state      = (i_sts.b_last_node && i_sts.b_last_level) ? S_IDLE : S_B_RD1;
                end
            end
            S_B_WR: begin
                o_cmd.b_wr   = 1'b1;
                o_cmd.b_next = 1'b1;
                n_state      = (i_sts.b_last_node && i_sts.b_last_level) ? S_IDLE : S_B_RD1;
            end
            S_Q_STEP: begin
                if (i_sts.q_end) begin
                    n_state = S_Q_DONE;
                end else if (i_sts.k_lsb) begin
                    o_cmd.q_rd = 1'b1;
                    n_state    = S_Q_WAIT;
                end else begin
                    o_cmd.q_shift = 1'b1;
                end
            end
            S_Q_WAIT: begin
                if (i_sts.rd_live) begin
                    o_cmd.q_shift  = 1'b1;
                    o_cmd.q_follow = 1'b1;
                    n_state        = S_Q_STEP;
                end else begin
                    o_cmd.q_fail = 1'b1;
                    n_state      = S_Q_DONE;
                end
            end
            S_Q_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_state != S_IDLE;
        end
    end

    `KABL_ASSERT(a_out_free, i_clk, i_rst_n, o_cmd.out_load, i_sts.out_free,
        "result loaded over a pending result")
    `KABL_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, take && (i_req_type == REQ_QUERY),
        o_stall, "query accepted without going busy")

endmodule

[hdl/kth_ancestor_binary_lifting.sv]
// ----------------------------------------------------------------------------
// kth_ancestor_binary_lifting
// Tree k-th ancestor engine with a binary lifting jump table.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_req_type, i_node_index,
// i_parent_index, i_steps_up. Output channel: o_valid / i_stall with
// o_ancestor_index and o_found; only query items produce a result.
// Config: i_cfg_we / i_cfg_data writes node_count (clamped to MAX_NODES);
// write it only while the engine is idle.
// Sequencing, all through the single read port of the jump table memory
// (one registered read per cycle):
//   load  - written on the accept edge.
//   build - per node a read of its own source entry, then, unless that
//           entry is -1 or past node_count, a read of the first hop; then
//           a write, for every node below node_count at each of
//           LOG_LEVELS-1 levels.
//   query - a step per bit of k to its top set bit, a wait per set bit, a result step.
// One item is processed at a time; o_stall is high while one is at work.
// A finished query waits in the result register while i_stall is high, and
// the next item can be accepted meanwhile.
// Reset clears the sequencer and the result valid flag and sets node_count to 1;
// the jump table is not cleared and must be loaded and built before queries.
// ----------------------------------------------------------------------------
module kth_ancestor_binary_lifting #(
    parameter int MAX_NODES  = kabl_pkg::DEF_MAX_NODES,
    parameter int LOG_LEVELS = kabl_pkg::DEF_LOG_LEVELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [kabl_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [kabl_pkg::REQ_W-1:0]           i_req_type,
    input  logic [kabl_pkg::NODE_W-1:0]          i_node_index,
    input  logic signed [kabl_pkg::PARENT_W-1:0] i_parent_index,
    input  logic [kabl_pkg::STEPS_W-1:0]         i_steps_up,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [kabl_pkg::NODE_W-1:0]          o_ancestor_index,
    output logic                                 o_found
);
    import kabl_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    kabl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    kabl_dp #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_node_index     (i_node_index),
        .i_parent_index   (i_parent_index),
        .i_steps_up       (i_steps_up),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_ancestor_index (o_ancestor_index),
        .o_found          (o_found)
    );

endmodule

[sim/kth_ancestor_checker.sv]
// ----------------------------------------------------------------------------
// kth_ancestor_checker
// Watches both channels and the node_count port of the k-th ancestor engine,
// keeps its own jump table, predicts every query answer and compares it
// with what comes out.
// ----------------------------------------------------------------------------
module kth_ancestor_checker #(
    parameter int MAX_NODES  = kabl_pkg::DEF_MAX_NODES,
    parameter int LOG_LEVELS = kabl_pkg::DEF_LOG_LEVELS
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [kabl_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_stall,
    input  logic [kabl_pkg::REQ_W-1:0]           i_req_type,
    input  logic [kabl_pkg::NODE_W-1:0]          i_node_index,
    input  logic signed [kabl_pkg::PARENT_W-1:0] i_parent_index,
    input  logic [kabl_pkg::STEPS_W-1:0]         i_steps_up,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic [kabl_pkg::NODE_W-1:0]          i_ancestor_index,
    input  logic                                 i_found,
    output int                                   o_answers_due,
    output int                                   o_mismatches
);
    import kabl_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              found;
    } t_answer;

    logic signed [PARENT_W-1:0] lift [MAX_NODES][LOG_LEVELS];
    int                         node_count;
    int                         errors = 0;
    t_answer                    expected_answers[$];

    assign o_mismatches = errors;

    task automatic report_mismatch(input string what);
        $display("%0t: mismatch: %s", $time, what);
        errors++;
    endtask

    function automatic void expect_answer(input t_answer ans);
        expected_answers = {expected_answers, ans};
    endfunction

    function automatic int active_nodes();
        return (node_count > MAX_NODES) ? MAX_NODES : node_count;
    endfunction

    // entries naming a node outside the active range act as the root marker
    function automatic int hop(input int from, input int level, input int cnt);
        int next;
        if (from < 0 || from >= cnt) return -1;
        next = int'(lift[from][level]);
        if (next < 0 || next >= cnt) return -1;
        return next;
    endfunction

    function automatic void build_levels();
        int cnt;
        cnt = active_nodes();
        for (int lv = 1; lv < LOG_LEVELS; lv++)
            for (int n = 0; n < cnt; n++)
                lift[n][lv] = PARENT_W'(hop(hop(n, lv - 1, cnt), lv - 1, cnt));
    endfunction

    function automatic t_answer climb(input int node, input logic [STEPS_W-1:0] k);
        t_answer ans;
        int      cnt;
        int      cur;
        logic    ok;
        cnt = active_nodes();
        cur = node;
        ok  = (node < cnt) && ((k >> LOG_LEVELS) == 0);
        for (int lv = 0; lv < LOG_LEVELS; lv++) begin
            if (ok && k[lv]) begin
                cur = hop(cur, lv, cnt);
                if (cur < 0) ok = 1'b0;
            end
        end
        ans.found    = ok;
        ans.ancestor = ok ? cur[NODE_W-1:0] : '0;
        return ans;
    endfunction

    function automatic void take_item(input logic [REQ_W-1:0] req,
                                      input logic [NODE_W-1:0] node,
                                      input logic signed [PARENT_W-1:0] parent,
                                      input logic [STEPS_W-1:0] k);
        case (req)
            REQ_LOAD: begin
                if (node < MAX_NODES)
                    lift[node][0] = (parent < 0) ? -PARENT_W'(1) : parent;
            end
            REQ_BUILD: begin
                build_levels();
            end
            REQ_QUERY: begin
                expect_answer(climb(int'(node), k));
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            node_count = 1;
            expected_answers.delete();
        end else begin
            if (i_cfg_we) node_count = int'(i_cfg_data);
            if (i_in_valid && !i_in_stall)
                take_item(i_req_type, i_node_index, i_parent_index, i_steps_up);
            if (i_out_valid && !i_out_stall) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0b with no query waiting",
                                              i_ancestor_index, i_found));
                end else begin
                    want = expected_answers.pop_front();
                    if (i_found !== want.found)
                        report_mismatch($sformatf("found got %0b want %0b",
                                                  i_found, want.found));
                    if (i_ancestor_index !== want.ancestor)
                        report_mismatch($sformatf("ancestor_index got %0d want %0d",
                                                  i_ancestor_index, want.ancestor));
                end
            end
        end
        o_answers_due <= expected_answers.size();
    end

endmodule

[sim/tb_kth_ancestor_binary_lifting.sv]
// ----------------------------------------------------------------------------
// tb_kth_ancestor_binary_lifting
// Loads random trees (chains, cycles, bad and out-of-range parents), builds
// the jump table and fires ancestor queries under several node counts, with
// random idle bursts on both channels. A checker predicts every answer.
// ----------------------------------------------------------------------------
module tb_kth_ancestor_binary_lifting;
    import kabl_pkg::*;

    localparam int MAX_NODES    = DEF_MAX_NODES;
    localparam int LOG_LEVELS   = DEF_LOG_LEVELS;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_GOAL    = 1800;
    localparam int CALM_TAIL    = 250;
    localparam int DRAIN_CYCLES = 2 * LOG_LEVELS + 12;
    localparam int STALL_LIMIT  = 100000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_W-1:0]           i_cfg_data;
    logic                       i_valid;
    logic                       o_stall;
    logic [REQ_W-1:0]           i_req_type;
    logic [NODE_W-1:0]          i_node_index;
    logic signed [PARENT_W-1:0] i_parent_index;
    logic [STEPS_W-1:0]         i_steps_up;
    logic                       o_valid;
    logic                       i_stall;
    logic [NODE_W-1:0]          o_ancestor_index;
    logic                       o_found;

    int   answers_due;
    int   mismatch_count;
    int   items_sent = 0;
    int   active     = 1;  // node_count as the engine sees it
    int   built_hi   = 0;  // nodes below this have every level written
    int   idle_run   = 0;
    logic in_calm    = 1'b0;
    logic out_calm   = 1'b0;

    kth_ancestor_binary_lifting #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_node_index     (i_node_index),
        .i_parent_index   (i_parent_index),
        .i_steps_up       (i_steps_up),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_ancestor_index (o_ancestor_index),
        .o_found          (o_found)
    );

    kth_ancestor_checker #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_req_type       (i_req_type),
        .i_node_index     (i_node_index),
        .i_parent_index   (i_parent_index),
        .i_steps_up       (i_steps_up),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_ancestor_index (o_ancestor_index),
        .i_found          (o_found),
        .o_answers_due    (answers_due),
        .o_mismatches     (mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side back-pressure
    initial begin
        int burst;
        burst   = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!out_calm && burst > 0) begin
                i_stall <= 1'b1;
                burst--;
            end else if (!out_calm && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                burst = $urandom_range(0, 14);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] req, input int node,
                             input int parent, input int k);
        if (items_sent >= ITEM_GOAL - CALM_TAIL) begin
            in_calm  = 1'b1;
            out_calm = 1'b1;
        end
        if (!in_calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_req_type     <= req;
        i_node_index   <= node[NODE_W-1:0];
        i_parent_index <= parent[PARENT_W-1:0];
        i_steps_up     <= k[STEPS_W-1:0];
        do @(posedge i_clk); while (o_stall);
        if (req != REQ_UNUSED) items_sent++;
    endtask

    task automatic write_count(input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        active = (value > MAX_NODES) ? MAX_NODES : value;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (answers_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic int pick_parent(input int node, input int n);
        int r;
        int p;
        r = $urandom_range(0, 99);
        if (r < 45)      p = node - 1;
        else if (r < 65) p = (node == 0) ? -1 : $urandom_range(0, node - 1);
        else if (r < 75) p = -1;
        else if (r < 85) p = (n == 0) ? 0 : $urandom_range(0, n - 1);
        else if (r < 93) p = $urandom_range((n < MAX_NODES) ? n : 0, MAX_NODES - 1);
        else             p = -int'($urandom_range(2, 1024));
        return p;
    endfunction

    // a climb may only touch table entries that a load or build wrote
    task automatic send_query(input int n);
        int node;
        int r;
        int k;
        if (n == 0 || $urandom_range(0, 9) == 0) node = $urandom_range(0, MAX_NODES - 1);
        else node = $urandom_range(0, n - 1);
        r = $urandom_range(0, 9);
        if (r < 5)      k = $urandom_range(0, (node < 1021) ? node + 2 : 1023);
        else if (r < 7) k = $urandom;
        else if (r < 9) k = 1 << $urandom_range(0, LOG_LEVELS - 1);
        else            k = 0;
        if (node < active && active > built_hi) k = 0;
        send_item(REQ_QUERY, node, $urandom, k);
    endtask

    task automatic send_noise(input int n);
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            send_item(REQ_UNUSED, $urandom, $urandom, $urandom);
        else if (r == 1 && n < MAX_NODES)
            send_item(REQ_LOAD, $urandom_range(n, MAX_NODES - 1),
                      pick_parent(n, n), $urandom);
        else
            send_query(n);
    endtask

    task automatic run_phase(input int cfg_value, input logic reload);
        int order [MAX_NODES];
        int n;
        int j;
        int tmp;
        int queries;
        int r;
        if (items_sent < ITEM_GOAL - CALM_TAIL) begin
            in_calm  = ($urandom_range(0, 3) == 0);
            out_calm = ($urandom_range(0, 3) == 0);
        end
        write_count(cfg_value);
        n = active;
        if (reload) begin
            for (int i = 0; i < n; i++) order[i] = i;
            for (int i = n - 1; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 9) == 0) send_noise(n);
                send_item(REQ_LOAD, order[i], pick_parent(order[i], n), $urandom);
            end
            send_item(REQ_BUILD, $urandom, $urandom, $urandom);
            if (n > built_hi) built_hi = n;
        end
        queries = (n > 64) ? 120 : $urandom_range(10, 50);
        for (int q = 0; q < queries; q++) begin
            r = $urandom_range(0, 19);
            if (r == 0 && n > 0)
                send_item(REQ_LOAD, $urandom_range(0, n - 1),
                          pick_parent($urandom_range(0, n - 1), n), $urandom);
            else if (r == 1 && n <= 64)
                send_item(REQ_BUILD, $urandom, $urandom, $urandom);
            else if (r == 2)
                send_noise(n);
            else
                send_query(n);
        end
        // the final query's answer also marks any earlier build as done
        send_query(n);
        drain();
    endtask

    task automatic directed_items();
        write_count(4);
        send_item(REQ_LOAD, 0, -1, 0);
        send_item(REQ_LOAD, 1, 0, 0);
        send_item(REQ_LOAD, 2, 1, 0);
        send_item(REQ_LOAD, 3, -1024, 1023);
        send_item(REQ_LOAD, 1023, 1023, 0);
        send_item(REQ_UNUSED, 1023, -1, 1023);
        send_item(REQ_BUILD, 0, 0, 0);
        built_hi = 4;
        send_item(REQ_QUERY, 2, 0, 0);
        send_item(REQ_QUERY, 2, 0, 1);
        send_item(REQ_QUERY, 2, 0, 2);
        send_item(REQ_QUERY, 2, 0, 3);
        send_item(REQ_QUERY, 3, 0, 1);
        send_item(REQ_QUERY, 0, 0, 0);
        send_item(REQ_QUERY, 1023, 0, 0);
        send_item(REQ_QUERY, 2, -1, 1023);
        send_item(REQ_QUERY, 4, 0, 1);
        // parent past the count, first with stale upper levels, then rebuilt
        send_item(REQ_LOAD, 2, 7, 0);
        send_item(REQ_QUERY, 2, 0, 1);
        send_item(REQ_QUERY, 2, 0, 2);
        send_item(REQ_BUILD, 0, 0, 0);
        send_item(REQ_QUERY, 2, 0, 2);
        // self loop climbs forever
        send_item(REQ_LOAD, 1, 1, 0);
        send_item(REQ_BUILD, 0, 0, 0);
        send_item(REQ_QUERY, 1, 0, 1023);
        drain();
    endtask

    initial begin
        int phase_no;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_req_type     = REQ_LOAD;
        i_node_index   = '0;
        i_parent_index = '0;
        i_steps_up     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        directed_items();
        run_phase(0, 1'b1);
        run_phase(1, 1'b1);
        phase_no = 0;
        while (items_sent < ITEM_GOAL) begin
            if (phase_no == 2) begin
                run_phase(2047, 1'b1);
                run_phase(1024, 1'b0);
            end else if (built_hi >= 2 && $urandom_range(0, 3) == 0) begin
                run_phase($urandom_range(1, built_hi), 1'b0);
            end else begin
                run_phase($urandom_range(2, 48), 1'b1);
            end
            phase_no++;
        end
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
